/* rtl/core/cdid_pkg.sv */
// Shared types, constants and digit helpers for the disc identifier unit.
`timescale 1ns / 1ps

package cdid_pkg;

	// Highest number of tracks that are counted.
	localparam int unsigned MAX_TRACKS = 99;

	// Field widths.
	localparam int unsigned MIN_W  = 7;
	localparam int unsigned SEC_W  = 6;
	localparam int unsigned ADDR_W = 13;
	localparam int unsigned DSUM_W = 6;
	localparam int unsigned SUM_W  = 12;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned ID_W   = 32;

	// Command queue between front and back.
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = 3;
	localparam int unsigned QCNT_W = 4;

	// Result slots in the back end.
	localparam int unsigned OSLOTS = 2;

	// One classified table entry as it leaves the front end.
	typedef struct packed {
		logic [ADDR_W-1:0] addr_sec;
		logic [DSUM_W-1:0] dsum;
		logic              leadout;
	} cmd_t;

	// One finished result.
	typedef struct packed {
		logic [ID_W-1:0] disc_id;
		logic            too_many;
		logic            bad_order;
	} res_t;

	// Decimal digit of v at place weight w, for v below ten times w.
	// The nine compares are independent of one another.
	function automatic logic [3:0] dec_digit(input logic [ADDR_W-1:0] v,
			input int unsigned w);
		logic [3:0] q;
		q = '0;
		for (int unsigned k = 1; k <= 9; k++) begin
			if (32'(v) >= k * w) begin
				q = 4'(k);
			end
		end
		return q;
	endfunction

	// What is left of v once digit q at weight w is taken off.
	function automatic logic [ADDR_W-1:0] dec_rest(input logic [ADDR_W-1:0] v,
			input logic [3:0] q, input int unsigned w);
		return v - ADDR_W'(32'(q) * w);
	endfunction

endpackage

/* rtl/core/cdid_front.sv */
// Front end: accepts table entries and works out seconds and digit sum in four stages.
`timescale 1ns / 1ps

module cdid_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [cdid_pkg::MIN_W-1:0]    minutes,
	input  logic [cdid_pkg::SEC_W-1:0]    seconds,
	input  logic                          is_leadout,
	input  logic [cdid_pkg::QCNT_W-1:0]   q_count,
	output logic                          cmd_valid,
	output cdid_pkg::cmd_t                cmd
);
	import cdid_pkg::*;

	logic                accept;
	logic [2:0]          inflight;
	logic [QCNT_W:0]     credit_used;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                lead_s1, lead_s2, lead_s3, lead_s4;
	logic [ADDR_W-1:0]   addr_s1, addr_s2, addr_s3, addr_s4;
	logic [2:0]          th_s2;
	logic [9:0]          rem_s2;
	logic [4:0]          psum_s3;
	logic [6:0]          rem_s3;
	logic [DSUM_W-1:0]   dsum_s4;

	logic [ADDR_W-1:0]   addr_in;
	logic [3:0]          th_d, hu_d, te_d;
	logic [ADDR_W-1:0]   rest_th, rest_hu, rest_te;

	// The queue takes every entry that leaves stage four, so a request is
	// only taken while the queue has room for everything still in flight.
	assign inflight    = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign credit_used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(inflight);
	assign full        = credit_used >= (QCNT_W+1)'(QDEPTH);
	assign accept      = push && !full;

	// Address in seconds: minutes times sixty as two shifts.
	assign addr_in = (ADDR_W'(minutes) << 6) - (ADDR_W'(minutes) << 2) + ADDR_W'(seconds);

	// Digit extraction, one decimal place per stage; tens and units share the last.
	assign th_d    = dec_digit(addr_s1, 1000);
	assign rest_th = dec_rest(addr_s1, th_d, 1000);
	assign hu_d    = dec_digit(ADDR_W'(rem_s2), 100);
	assign rest_hu = dec_rest(ADDR_W'(rem_s2), hu_d, 100);
	assign te_d    = dec_digit(ADDR_W'(rem_s3), 10);
	assign rest_te = dec_rest(ADDR_W'(rem_s3), te_d, 10);

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		addr_s1 <= addr_in;
		lead_s1 <= is_leadout;

		addr_s2 <= addr_s1;
		lead_s2 <= lead_s1;
		th_s2   <= th_d[2:0];
		rem_s2  <= rest_th[9:0];

		addr_s3 <= addr_s2;
		lead_s3 <= lead_s2;
		psum_s3 <= 5'(th_s2) + 5'(hu_d);
		rem_s3  <= rest_hu[6:0];

		addr_s4 <= addr_s3;
		lead_s4 <= lead_s3;
		dsum_s4 <= DSUM_W'(psum_s3) + DSUM_W'(te_d) + DSUM_W'(rest_te[3:0]);
	end

	assign cmd_valid    = v_s4;
	assign cmd.addr_sec = addr_s4;
	assign cmd.dsum     = dsum_s4;
	assign cmd.leadout  = lead_s4;

endmodule

/* rtl/core/cdid_queue.sv */
// Command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module cdid_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  cdid_pkg::cmd_t              wr_data,
	input  logic                        rd_en,
	output cdid_pkg::cmd_t              rd_data,
	output logic                        empty,
	output logic [cdid_pkg::QCNT_W-1:0] count
);
	import cdid_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = ent_q[rd_ptr_q];
	assign empty   = count_q == '0;
	assign count   = count_q;

	// The front end's credit check must keep the queue from overflowing.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q != QCNT_W'(QDEPTH)))
		else $error("command queue written while full");

	// The back end only drains entries that are there.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("command queue read while empty");

endmodule

/* rtl/core/cdid_back.sv */
// Back end: accumulates track entries and builds the identifier on the lead-out.
`timescale 1ns / 1ps

module cdid_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  cdid_pkg::cmd_t              q_head,
	output logic                        q_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [cdid_pkg::ID_W-1:0]   disc_id,
	output logic                        too_many_tracks,
	output logic                        bad_order
);
	import cdid_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] first_q;
	logic              ovf_q;

	res_t              oslot_q [OSLOTS];
	logic [1:0]        ocnt_q;

	logic              proceed;
	logic              do_push;
	logic              do_pop;
	logic              wr_idx;
	logic              late;
	logic [LEN_W-1:0]  length;
	logic [8:0]        fold;
	logic [7:0]        sum_mod;
	res_t              res;

	// An entry is taken unless it is a lead-out with no free result slot.
	assign proceed = !q_empty && (!q_head.leadout || (ocnt_q != 2'(OSLOTS)));
	assign q_pop   = proceed;
	assign do_push = proceed && q_head.leadout;
	assign do_pop  = pop && (ocnt_q != '0);
	assign wr_idx  = 1'((ocnt_q - 2'(do_pop)) & 2'd1);

	// Length from first track start, zero when the lead-out comes too early.
	assign late   = q_head.addr_sec < first_q;
	assign length = late ? '0 : LEN_W'(q_head.addr_sec - first_q);

	// Sum modulo 255: fold the upper nibble onto the low byte, then one subtract.
	assign fold    = 9'(sum_q[11:8]) + 9'(sum_q[7:0]);
	assign sum_mod = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];

	assign res.disc_id   = {sum_mod, length, 1'b0, count_q};
	assign res.too_many  = ovf_q;
	assign res.bad_order = late;

	// Disc state and result slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			first_q <= '0;
			ovf_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			ocnt_q <= ocnt_q + 2'(do_push) - 2'(do_pop);
			if (proceed) begin
				if (q_head.leadout) begin
					sum_q   <= '0;
					count_q <= '0;
					first_q <= '0;
					ovf_q   <= 1'b0;
				end else if (count_q >= CNT_W'(MAX_TRACKS)) begin
					ovf_q <= 1'b1;
				end else begin
					if (count_q == '0) begin
						first_q <= q_head.addr_sec;
					end
					sum_q   <= sum_q + SUM_W'(q_head.dsum);
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Result slots: the oldest sits in slot zero. A new result lands in slot
	// zero when it is the only one left after this cycle's pop.
	always_ff @(posedge clk) begin
		if (do_push && (wr_idx == 1'b0)) begin
			oslot_q[0] <= res;
		end else if (do_pop) begin
			oslot_q[0] <= oslot_q[1];
		end
		if (do_push && (wr_idx == 1'b1)) begin
			oslot_q[1] <= res;
		end
	end

	assign empty           = ocnt_q == '0;
	assign disc_id         = oslot_q[0].disc_id;
	assign too_many_tracks = oslot_q[0].too_many;
	assign bad_order       = oslot_q[0].bad_order;

	// The slot count never passes the number of slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'(OSLOTS))
		else $error("result slots overrun");

	// Tracks beyond the limit are never counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRACKS))
		else $error("track count beyond limit");

endmodule

/* rtl/core/cd_toc_disc_id_unit.sv */
// A lead-out request's result shows after it has passed the four front stages and the command queue.
// Throughput: one request per cycle; push is refused (full) while the command
// queue and the four front stages together hold eight entries.
// Two result slots let requests flow while a result waits to be popped.
// Reset (arst_n low) empties all queues and clears the disc state at once.
`timescale 1ns / 1ps

module cd_toc_disc_id_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [cdid_pkg::MIN_W-1:0]  minutes,
	input  logic [cdid_pkg::SEC_W-1:0]  seconds,
	input  logic                        is_leadout,
	output logic                        empty,
	input  logic                        pop,
	output logic [cdid_pkg::ID_W-1:0]   disc_id,
	output logic                        too_many_tracks,
	output logic                        bad_order
);
	import cdid_pkg::*;

	logic              cmd_valid;
	cmd_t              cmd;
	cmd_t              q_head;
	logic              q_empty;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;

	// Front end: accepts and classifies requests.
	cdid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.minutes    (minutes),
		.seconds    (seconds),
		.is_leadout (is_leadout),
		.q_count    (q_count),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	// Queue between the two halves.
	cdid_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty),
		.count   (q_count)
	);

	// Back end: accumulation and result output.
	cdid_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.disc_id         (disc_id),
		.too_many_tracks (too_many_tracks),
		.bad_order       (bad_order)
	);

endmodule

/* sim/tb.sv */
// Self-checking testbench for the disc identifier unit, with its own predictor of the identifier.
`timescale 1ns / 1ps

module tb;
	import cdid_pkg::*;

	// One table-of-contents entry, as it is offered on the request side.
	typedef struct {
		logic [MIN_W-1:0] mins;
		logic [SEC_W-1:0] secs;
		logic             lead;
	} toc_entry_t;

	// One disc identifier with its two flags, as predicted.
	typedef struct {
		logic [ID_W-1:0] id;
		logic            too_many;
		logic            bad;
	} disc_result_t;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned TARGET_ITEMS = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [MIN_W-1:0] minutes = '0;
	logic [SEC_W-1:0] seconds = '0;
	logic is_leadout = 1'b0;
	logic full;
	logic empty;
	logic [ID_W-1:0] disc_id;
	logic too_many_tracks;
	logic bad_order;

	toc_entry_t toc_entries[$];
	disc_result_t awaited_ids[$];
	int unsigned total_entries = 0;
	int unsigned entries_taken = 0;
	int unsigned entry_idx = 0;
	int unsigned quiet_cycles = 0;
	bit failed = 1'b0;

	// Predictor state for the disc being assembled.
	logic [SUM_W-1:0]  sum_acc = '0;
	logic [CNT_W-1:0]  track_cnt = '0;
	logic [ADDR_W-1:0] first_start = '0;
	logic              overflow_flag = 1'b0;

	cd_toc_disc_id_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.minutes(minutes),
		.seconds(seconds),
		.is_leadout(is_leadout),
		.empty(empty),
		.pop(pop),
		.disc_id(disc_id),
		.too_many_tracks(too_many_tracks),
		.bad_order(bad_order)
	);

	always #5 clk = ~clk;

	// Sum of the decimal digits of an address in seconds.
	function automatic int unsigned digit_total(input int unsigned v);
		int unsigned acc;
		acc = 0;
		while (v != 0) begin
			acc += v % 10;
			v /= 10;
		end
		return acc;
	endfunction

	function automatic void add_entry(input int unsigned m, input int unsigned s,
			input bit lo);
		toc_entry_t e;
		e.mins = MIN_W'(m);
		e.secs = SEC_W'(s);
		e.lead = lo;
		toc_entries.push_back(e);
	endfunction

	// Adds an entry at a time given in seconds, kept within the usual disc range.
	function automatic void add_time(input int unsigned t, input bit lo);
		if (t > 5999) begin
			t = 5999;
		end
		add_entry(t / 60, t % 60, lo);
	endfunction

	// Updates the disc state for one accepted entry and records any identifier it yields.
	task automatic predict_entry(input toc_entry_t e);
		logic [ADDR_W-1:0] addr;
		disc_result_t r;
		logic [LEN_W-1:0] len;
		addr = ADDR_W'(int'(e.mins) * 60 + int'(e.secs));
		if (!e.lead) begin
			if (track_cnt >= CNT_W'(MAX_TRACKS)) begin
				overflow_flag = 1'b1;
			end else begin
				if (track_cnt == 0) begin
					first_start = addr;
				end
				sum_acc = sum_acc + SUM_W'(digit_total(addr));
				track_cnt = track_cnt + 1'b1;
			end
		end else begin
			r.bad = (addr < first_start);
			len = r.bad ? '0 : LEN_W'(addr - first_start);
			r.id = {8'(sum_acc % 255), len, 8'(track_cnt)};
			r.too_many = overflow_flag;
			awaited_ids.push_back(r);
			sum_acc = '0;
			track_cnt = '0;
			first_start = '0;
			overflow_flag = 1'b0;
		end
	endtask

	// Monitor: predicts on each accepted request and checks each popped result.
	always @(posedge clk) begin
		toc_entry_t cur;
		disc_result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pop && !empty) begin
				moved = 1'b1;
				if (awaited_ids.size() == 0) begin
					$error("unexpected result: disc_id %h", disc_id);
					failed = 1'b1;
				end else begin
					want = awaited_ids.pop_front();
					if (disc_id !== want.id) begin
						$error("disc_id: expected %h, got %h", want.id, disc_id);
						failed = 1'b1;
					end
					if (too_many_tracks !== want.too_many) begin
						$error("too_many_tracks: expected %b, got %b", want.too_many,
							too_many_tracks);
						failed = 1'b1;
					end
					if (bad_order !== want.bad) begin
						$error("bad_order: expected %b, got %b", want.bad, bad_order);
						failed = 1'b1;
					end
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				cur.mins = minutes;
				cur.secs = seconds;
				cur.lead = is_leadout;
				predict_entry(cur);
				entries_taken = entries_taken + 1;
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// Driver: offers the queued entries and drives pop, with idling by phase of the run.
	always @(negedge clk) begin
		int unsigned phase;
		int unsigned send_idle;
		int unsigned recv_idle;
		bit taken;
		if (arst_n) begin
			phase = (entries_taken * 3) / (total_entries + 1);
			send_idle = (phase == 0) ? 21 : (phase == 1) ? 63 : 0;
			recv_idle = (phase == 0) ? 63 : (phase == 1) ? 21 : 0;
			taken = (entries_taken > entry_idx);
			if (taken) begin
				entry_idx = entry_idx + 1;
			end
			if (push && !taken) begin
				// The request is still waiting, so it is held as it is.
			end else if (entry_idx < toc_entries.size() &&
					$urandom_range(0, 99) >= send_idle) begin
				push <= 1'b1;
				minutes <= toc_entries[entry_idx].mins;
				seconds <= toc_entries[entry_idx].secs;
				is_leadout <= toc_entries[entry_idx].lead;
			end else begin
				push <= 1'b0;
			end
			pop <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("cd_toc_disc_id_unit test failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned disc_no;
		int unsigned ntr;
		int unsigned t;
		int unsigned style;
		// Lead-out with no tracks, at both ends of the address range.
		add_entry(0, 0, 1);
		add_entry(127, 63, 1);
		// Extreme addresses as tracks, lead-out at the largest address.
		add_entry(0, 0, 0);
		add_entry(99, 59, 0);
		add_entry(127, 63, 0);
		add_entry(127, 63, 1);
		// Lead-out before the first track.
		add_entry(50, 0, 0);
		add_entry(10, 0, 1);
		// Lead-out equal to the first track start.
		add_entry(2, 0, 0);
		add_entry(5, 30, 0);
		add_entry(2, 0, 1);
		// An ordinary short disc.
		add_entry(0, 2, 0);
		add_entry(60, 30, 1);

		// Random discs: mostly well formed, some with too many tracks, some noise.
		disc_no = 0;
		while (toc_entries.size() < TARGET_ITEMS) begin
			style = $urandom_range(0, 99);
			if (disc_no == 0 || style < 3) begin
				ntr = $urandom_range(95, 110);
			end else if (style < 8) begin
				ntr = 0;
			end else begin
				ntr = $urandom_range(1, 20);
			end
			if (style >= 88) begin
				// Noise: any field values, with the lead-out mark at random.
				repeat (ntr) begin
					add_entry($urandom_range(0, 127), $urandom_range(0, 63),
						$urandom_range(0, 9) == 0);
				end
				add_entry($urandom_range(0, 127), $urandom_range(0, 63), 1);
			end else begin
				t = $urandom_range(0, 300);
				repeat (ntr) begin
					if ($urandom_range(0, 19) == 0) begin
						add_entry($urandom_range(0, 127), $urandom_range(0, 63), 0);
					end else begin
						add_time(t, 0);
					end
					t += (ntr > 50) ? $urandom_range(1, 60) : $urandom_range(60, 600);
				end
				if ($urandom_range(0, 9) == 0) begin
					add_entry($urandom_range(0, 127), $urandom_range(0, 63), 1);
				end else begin
					add_time(t + $urandom_range(0, 600), 1);
				end
			end
			disc_no++;
		end
		total_entries = toc_entries.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (entry_idx >= total_entries && awaited_ids.size() == 0);
		repeat (20) @(posedge clk);
		if (!failed) begin
			$display("cd_toc_disc_id_unit test passed");
		end else begin
			$display("cd_toc_disc_id_unit test failed");
		end
		$finish;
	end

endmodule
